// ===== hw/rtl/rtp_sequence_loss_tracker_macros.svh =====
// Assertion helpers for the sequence loss tracker.
`ifndef RTP_SEQUENCE_LOSS_TRACKER_MACROS_SVH
`define RTP_SEQUENCE_LOSS_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RTPSLT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RTPSLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rtpslt_pkg.sv =====
package rtpslt_pkg;

    localparam int SEQ_W = 16;
    localparam int PT_W  = 7;
    localparam int LEN_W = 16;
    localparam int GAP_W = 15;
    localparam int EXT_W = 32;
    localparam int CNT_W = 32;

    // Serial-number half cycle: a distance of this or more is not ahead
    localparam logic [SEQ_W-1:0] SEQ_HALF = 16'h8000;

    typedef enum logic [1:0] {
        VERDICT_RECEIVED  = 2'd0,
        VERDICT_DISCARDED = 2'd1,
        VERDICT_FEC       = 2'd2
    } verdict_t;

    // Sequence tracking state
    typedef struct packed {
        logic             started;
        logic [SEQ_W-1:0] highest;
        logic [SEQ_W-1:0] wraps;
    } track_t;

    // Per-word classification handed from the update logic to the top
    typedef struct packed {
        verdict_t         verdict;
        logic [EXT_W-1:0] ext;
        logic [GAP_W-1:0] gap;
        logic [EXT_W-1:0] gap_first;
        track_t           track_next;
    } upd_t;

endpackage

// ===== hw/rtl/rtpslt_ifs.sv =====
// Packet header channel
interface rtpslt_hdr_if;
    logic                       valid;
    logic                       ready;
    logic [rtpslt_pkg::SEQ_W-1:0] sequence_number;
    logic [rtpslt_pkg::PT_W-1:0]  payload_kind;
    logic [rtpslt_pkg::LEN_W-1:0] payload_bytes;

    modport source (output valid, sequence_number, payload_kind, payload_bytes,
                    input ready);
    modport sink   (input valid, sequence_number, payload_kind, payload_bytes,
                    output ready);
endinterface

// Result channel
interface rtpslt_res_if;
    logic                         valid;
    logic                         ready;
    rtpslt_pkg::verdict_t         verdict;
    logic [rtpslt_pkg::EXT_W-1:0] extended_sequence;
    logic [rtpslt_pkg::GAP_W-1:0] gap_length;
    logic [rtpslt_pkg::EXT_W-1:0] gap_first_extended;
    logic [rtpslt_pkg::CNT_W-1:0] received_count;
    logic [rtpslt_pkg::CNT_W-1:0] received_byte_total;
    logic [rtpslt_pkg::CNT_W-1:0] lost_count;
    logic [rtpslt_pkg::CNT_W-1:0] discarded_count;
    logic [rtpslt_pkg::CNT_W-1:0] discarded_byte_total;
    logic [rtpslt_pkg::CNT_W-1:0] fec_count;
    logic [rtpslt_pkg::CNT_W-1:0] fec_byte_total;

    modport source (output valid, verdict, extended_sequence, gap_length,
                    gap_first_extended, received_count, received_byte_total,
                    lost_count, discarded_count, discarded_byte_total,
                    fec_count, fec_byte_total,
                    input ready);
    modport sink   (input valid, verdict, extended_sequence, gap_length,
                    gap_first_extended, received_count, received_byte_total,
                    lost_count, discarded_count, discarded_byte_total,
                    fec_count, fec_byte_total,
                    output ready);
endinterface

// ===== hw/rtl/rtpslt_seq_update.sv =====
// Classifies one header against the tracking state: FEC, first packet,
// late/duplicate, or ahead with a possible lost range.
module rtpslt_seq_update (
    input  rtpslt_pkg::track_t             track,
    input  logic [rtpslt_pkg::PT_W-1:0]    fec_type,
    input  logic [rtpslt_pkg::SEQ_W-1:0]   seq,
    input  logic [rtpslt_pkg::PT_W-1:0]    kind,
    output rtpslt_pkg::upd_t               upd
);
    import rtpslt_pkg::*;

    logic             fec_hit;
    logic [SEQ_W-1:0] seq_delta;
    logic [SEQ_W-1:0] gap_full;
    logic             ahead;
    logic             wrapped;
    logic [EXT_W-1:0] highest_ext;

    // serial compare against the highest number seen
    assign fec_hit     = (fec_type != '0) && (kind == fec_type);
    assign seq_delta   = seq - track.highest;
    assign ahead       = (seq_delta != '0) && (seq_delta < SEQ_HALF);
    assign gap_full    = seq_delta - SEQ_W'(1);
    assign wrapped     = seq < track.highest;
    // carry out of the low half steps the wrap count when highest is all ones
    assign highest_ext = {track.wraps, track.highest};

    always_comb
    begin
        upd.verdict    = VERDICT_DISCARDED;
        upd.ext        = {track.wraps, seq};
        upd.gap        = '0;
        upd.gap_first  = '0;
        upd.track_next = track;
        priority if (fec_hit)
        begin
            upd.verdict = VERDICT_FEC;
        end
        else if (!track.started)
        begin
            upd.verdict            = VERDICT_RECEIVED;
            upd.ext                = {{SEQ_W{1'b0}}, seq};
            upd.track_next.started = 1'b1;
            upd.track_next.highest = seq;
            upd.track_next.wraps   = '0;
        end
        else if (ahead)
        begin
            upd.verdict            = VERDICT_RECEIVED;
            upd.gap                = gap_full[GAP_W-1:0];
            if (gap_full != '0)
                upd.gap_first = highest_ext + EXT_W'(1);
            upd.track_next.highest = seq;
            if (wrapped)
                upd.track_next.wraps = track.wraps + SEQ_W'(1);
            upd.ext                = {upd.track_next.wraps, seq};
        end
        else
        begin
            upd.verdict = VERDICT_DISCARDED;
        end
    end

endmodule

// ===== hw/rtl/rtp_sequence_loss_tracker.sv =====
// RTP sequence loss tracker.
// hdr (sink): one packet header word per handshake: sequence number,
//   payload type and payload size. res (source): one result word per
//   header: verdict, extended sequence, lost range and running totals.
// cfg_we/cfg_wdata write the FEC payload type (0 disables FEC detection);
//   write it only while no header is in flight.
// A header accepted into the input register passes the state update and is
//   registered into the result register. One header per cycle while res is
//   not stalled; the state update is one serial compare, a subtract and the
//   counter adds, all between the input and result registers.
// Reset clears tracking, the wrap count, all totals, the FEC type and both
//   valid flags; the first non-FEC header after reset starts tracking.
// When res is stalled the result register holds its word and the input
//   register takes one more header; hdr.ready then drops until res drains.
module rtp_sequence_loss_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    rtpslt_hdr_if.sink                    hdr,
    rtpslt_res_if.source                  res,
    input  logic                          cfg_we,
    input  logic [rtpslt_pkg::PT_W-1:0]   cfg_wdata
);
    import rtpslt_pkg::*;

    `include "rtp_sequence_loss_tracker_macros.svh"

    logic [PT_W-1:0]  fec_type_reg;
    logic             in_valid_reg;
    logic [SEQ_W-1:0] in_seq_reg;
    logic [PT_W-1:0]  in_kind_reg;
    logic [LEN_W-1:0] in_bytes_reg;
    logic             out_valid_reg;
    track_t           track_reg;
    upd_t             upd;
    logic             advance;
    logic [CNT_W-1:0] bytes_ext;

    logic [CNT_W-1:0] rx_cnt_reg, rx_cnt_next;
    logic [CNT_W-1:0] rx_byt_reg, rx_byt_next;
    logic [CNT_W-1:0] lost_reg, lost_next;
    logic [CNT_W-1:0] dis_cnt_reg, dis_cnt_next;
    logic [CNT_W-1:0] dis_byt_reg, dis_byt_next;
    logic [CNT_W-1:0] fec_cnt_reg, fec_cnt_next;
    logic [CNT_W-1:0] fec_byt_reg, fec_byt_next;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fec_type_reg <= '0;
        else if (cfg_we)
            fec_type_reg <= cfg_wdata;
    end

    // input register moves on when the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign hdr.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (hdr.ready)
            in_valid_reg <= hdr.valid;
    end

    always_ff @(posedge clk)
    begin
        if (hdr.valid && hdr.ready)
        begin
            in_seq_reg   <= hdr.sequence_number;
            in_kind_reg  <= hdr.payload_kind;
            in_bytes_reg <= hdr.payload_bytes;
        end
    end

    rtpslt_seq_update u_update (
        .track    (track_reg),
        .fec_type (fec_type_reg),
        .seq      (in_seq_reg),
        .kind     (in_kind_reg),
        .upd      (upd)
    );

    // running totals after this word
    assign bytes_ext = {{(CNT_W-LEN_W){1'b0}}, in_bytes_reg};

    always_comb
    begin
        rx_cnt_next  = rx_cnt_reg;
        rx_byt_next  = rx_byt_reg;
        lost_next    = lost_reg + {{(CNT_W-GAP_W){1'b0}}, upd.gap};
        dis_cnt_next = dis_cnt_reg;
        dis_byt_next = dis_byt_reg;
        fec_cnt_next = fec_cnt_reg;
        fec_byt_next = fec_byt_reg;
        unique case (upd.verdict)
            VERDICT_RECEIVED:
            begin
                rx_cnt_next = rx_cnt_reg + CNT_W'(1);
                rx_byt_next = rx_byt_reg + bytes_ext;
            end
            VERDICT_DISCARDED:
            begin
                dis_cnt_next = dis_cnt_reg + CNT_W'(1);
                dis_byt_next = dis_byt_reg + bytes_ext;
            end
            VERDICT_FEC:
            begin
                fec_cnt_next = fec_cnt_reg + CNT_W'(1);
                fec_byt_next = fec_byt_reg + bytes_ext;
            end
            default:
            begin
                rx_cnt_next = rx_cnt_reg;
            end
        endcase
    end

    // tracking state and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg   <= '0;
            rx_cnt_reg  <= '0;
            rx_byt_reg  <= '0;
            lost_reg    <= '0;
            dis_cnt_reg <= '0;
            dis_byt_reg <= '0;
            fec_cnt_reg <= '0;
            fec_byt_reg <= '0;
        end
        else if (advance)
        begin
            track_reg   <= upd.track_next;
            rx_cnt_reg  <= rx_cnt_next;
            rx_byt_reg  <= rx_byt_next;
            lost_reg    <= lost_next;
            dis_cnt_reg <= dis_cnt_next;
            dis_byt_reg <= dis_byt_next;
            fec_cnt_reg <= fec_cnt_next;
            fec_byt_reg <= fec_byt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res.verdict              <= upd.verdict;
            res.extended_sequence    <= upd.ext;
            res.gap_length           <= upd.gap;
            res.gap_first_extended   <= upd.gap_first;
            res.received_count       <= rx_cnt_next;
            res.received_byte_total  <= rx_byt_next;
            res.lost_count           <= lost_next;
            res.discarded_count      <= dis_cnt_next;
            res.discarded_byte_total <= dis_byt_next;
            res.fec_count            <= fec_cnt_next;
            res.fec_byte_total       <= fec_byt_next;
        end
    end

    assign res.valid = out_valid_reg;

    // checks
    `RTPSLT_ASSERT_IMP(a_gap_only_received, clk, rst_n,
        res.valid && (res.verdict != VERDICT_RECEIVED),
        (res.gap_length == '0) && (res.gap_first_extended == '0),
        "lost range reported on a word that was not received")
    `RTPSLT_ASSERT_NEXT(a_stalled_word_held, clk, rst_n,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_seq_reg),
        "input register lost a stalled header")
    `RTPSLT_ASSERT_NEXT(a_lost_tracks_gap, clk, rst_n,
        advance,
        lost_reg == $past(lost_reg) + {{(CNT_W-GAP_W){1'b0}}, $past(upd.gap)},
        "lost total does not follow the reported gap")

endmodule
